// ===== rtl/core/ratio_key_stable_sorter_macros.svh =====
// Assertion macros shared by the ratio key sorter RTL.
`ifndef RATIO_KEY_STABLE_SORTER_MACROS_SVH
`define RATIO_KEY_STABLE_SORTER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RKS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("ratio key sorter: same-cycle check failed");

`define RKS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("ratio key sorter: next-cycle check failed");

`else

`define RKS_ASSERT_SAME(label, clk, rst_n, cond, prop)

`define RKS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/core/rks_pkg.sv =====
// Package with item layout, widths and key helpers for the ratio key sorter.
`default_nettype none

package rks_pkg;

    localparam int DEFAULT_MAX_ITEMS = 64;
    localparam int CAP_W = 16;
    localparam int POW_W = 16;
    localparam int TAG_W = 8;
    localparam int PROD_W = CAP_W + POW_W;
    localparam int ITEM_W = CAP_W + POW_W + TAG_W;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [POW_W-1:0] power;
        logic [CAP_W-1:0] capacity;
    } item_t;

    // A zero power compares as the smallest legal power.
    function automatic logic [POW_W-1:0] key_power(input logic [POW_W-1:0] p);
        key_power = (p == '0) ? POW_W'(1) : p;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ratio_key_stable_sorter.sv =====
// Ratio key stable sorter: stores a set of items and emits it in key order.
//
//  channel  | direction | handshake           | content
//  ---------+-----------+---------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready | item capacity, power, tag; tlast
//  m_       | out       | m_tvalid / m_tready | sorted tag, capacity, power; flags
//  cfg_     | in        | cfg_we              | efficiency mode bit
//
// A load beat takes one cycle. On the last beat of a set of n items the block
// ranks every item by scanning the item memory once per item through its single
// read port, then emits the results one at a time via S_OREAD, S_OIDX, S_ODATA,
// S_OUT, waiting in S_OUT for m_tready. No load beat is taken while a set is
// ranked or emitted. Reset clears the item count, the drop flag and sets efficiency mode.
`default_nettype none

`include "ratio_key_stable_sorter_macros.svh"

module ratio_key_stable_sorter #(
    parameter int MAX_ITEMS = rks_pkg::DEFAULT_MAX_ITEMS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // item_capacity[15:0], item_power[31:16], item_tag[39:32]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // out_tag[7:0], out_capacity[23:8], out_power[39:24]
    output logic             m_tuser,  // overflow_flag[0]
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [3:0] {
        S_LOAD,
        S_CUR,
        S_CURW,
        S_SCAN,
        S_DRAIN,
        S_OREAD,
        S_OIDX,
        S_ODATA,
        S_OUT
    } state_t;

    state_t state_reg;

    rks_pkg::item_t item_mem [MAX_ITEMS];
    logic [IDX_W-1:0] order_mem [MAX_ITEMS];

    rks_pkg::item_t item_rd_reg;
    logic [IDX_W-1:0] ord_rd_reg;

    logic [CNT_W-1:0] count_reg;
    logic dropped_reg;
    logic mode_reg;

    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] rank_reg;

    logic [rks_pkg::CAP_W-1:0] cur_cap_reg;
    logic [rks_pkg::POW_W-1:0] cur_kp_reg;

    logic v1_reg;
    logic v2_reg;
    logic [IDX_W-1:0] j1_reg;
    logic [IDX_W-1:0] j2_reg;
    logic [rks_pkg::PROD_W-1:0] prod_ji_reg;
    logic [rks_pkg::PROD_W-1:0] prod_ij_reg;
    logic [rks_pkg::POW_W-1:0] kp2_reg;

    logic m_tvalid_reg;
    logic m_tlast_reg;
    logic m_tuser_reg;
    logic [39:0] m_tdata_reg;

    logic store_we;
    logic load_beat;
    logic order_we;
    logic [IDX_W-1:0] item_raddr;
    logic [CNT_W-1:0] last_pos;
    logic j_is_last;
    logic i_is_last;
    logic k_is_last;
    logic [rks_pkg::POW_W-1:0] kp_j;
    logic eq_prod;
    logic i_less_j_eff;
    logic eq_eff;
    logic j_ahead;

    assign s_tready  = (state_reg == S_LOAD);
    assign load_beat = s_tvalid && s_tready;
    assign store_we  = load_beat && (count_reg < CNT_W'(MAX_ITEMS));
    assign order_we  = (state_reg == S_DRAIN) && !v1_reg && !v2_reg;

    assign last_pos  = count_reg - CNT_W'(1);
    assign j_is_last = (CNT_W'(j_reg) == last_pos);
    assign i_is_last = (CNT_W'(i_reg) == last_pos);
    assign k_is_last = (CNT_W'(k_reg) == last_pos);

    always_comb begin
        unique case (state_reg)
            S_CUR:   item_raddr = i_reg;
            S_SCAN:  item_raddr = j_reg;
            default: item_raddr = ord_rd_reg;
        endcase
    end

    // Item j takes a place ahead of item i in the emitted order.
    assign kp_j         = rks_pkg::key_power(item_rd_reg.power);
    assign eq_prod      = (prod_ji_reg == prod_ij_reg);
    assign i_less_j_eff = eq_prod ? (cur_kp_reg < kp2_reg) : (prod_ij_reg < prod_ji_reg);
    assign eq_eff       = eq_prod && (cur_kp_reg == kp2_reg);
    assign j_ahead = mode_reg ? (i_less_j_eff || (eq_eff && (j2_reg > i_reg)))
                              : ((kp2_reg < cur_kp_reg) ||
                                 ((kp2_reg == cur_kp_reg) && (j2_reg < i_reg)));

    always_ff @(posedge aclk) begin
        if (store_we) begin
            item_mem[count_reg[IDX_W-1:0]] <= rks_pkg::item_t'(s_tdata);
        end
        item_rd_reg <= item_mem[item_raddr];
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[rank_reg] <= i_reg;
        end
        ord_rd_reg <= order_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        j1_reg      <= j_reg;
        j2_reg      <= j1_reg;
        prod_ji_reg <= {16'b0, item_rd_reg.capacity} * {16'b0, cur_kp_reg};
        prod_ij_reg <= {16'b0, cur_cap_reg} * {16'b0, kp_j};
        kp2_reg     <= kp_j;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            mode_reg     <= 1'b1;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            v1_reg <= (state_reg == S_SCAN);
            v2_reg <= v1_reg;
            if (v2_reg && j_ahead) begin
                rank_reg <= rank_reg + IDX_W'(1);
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (load_beat) begin
                        if (store_we) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            i_reg     <= '0;
                            state_reg <= S_CUR;
                        end
                    end
                end
                S_CUR: begin
                    rank_reg  <= '0;
                    state_reg <= S_CURW;
                end
                S_CURW: begin
                    cur_cap_reg <= item_rd_reg.capacity;
                    cur_kp_reg  <= kp_j;
                    j_reg       <= '0;
                    state_reg   <= S_SCAN;
                end
                S_SCAN: begin
                    if (j_is_last) begin
                        state_reg <= S_DRAIN;
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (order_we) begin
                        if (i_is_last) begin
                            k_reg     <= '0;
                            state_reg <= S_OREAD;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_CUR;
                        end
                    end
                end
                S_OREAD: begin
                    state_reg <= S_OIDX;
                end
                S_OIDX: begin
                    state_reg <= S_ODATA;
                end
                S_ODATA: begin
                    m_tdata_reg  <= {item_rd_reg.power, item_rd_reg.capacity, item_rd_reg.tag};
                    m_tuser_reg  <= dropped_reg;
                    m_tlast_reg  <= k_is_last;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (k_is_last) begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= S_LOAD;
                        end else begin
                            k_reg     <= k_reg + IDX_W'(1);
                            state_reg <= S_OREAD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `RKS_ASSERT_SAME(a_no_load_during_output, aclk, aresetn, m_tvalid, !s_tready)
    `RKS_ASSERT_SAME(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_ITEMS))
    `RKS_ASSERT_SAME(a_rank_in_set, aclk, aresetn, order_we, CNT_W'(rank_reg) < count_reg)
    `RKS_ASSERT_SAME(a_scan_empty_at_start, aclk, aresetn, state_reg == S_CUR, !v1_reg && !v2_reg)
    `RKS_ASSERT_NEXT(a_set_closes, aclk, aresetn, m_tvalid && m_tready && m_tlast,
                     s_tready && (count_reg == '0) && !dropped_reg)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the ratio key stable sorter with a built-in ranking predictor.
module tb_top;

    localparam int unsigned SLOTS = rks_pkg::DEFAULT_MAX_ITEMS;
    localparam bit MODE_RATIO = 1'b1;
    localparam bit MODE_POWER = 1'b0;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 600;

    typedef struct packed {
        logic [7:0]  tag;
        logic [15:0] capacity;
        logic [15:0] power;
        logic        overflow;
        logic        last;
    } ranked_beat_t;

    class sorted_set_predictor;
        rks_pkg::item_t held[SLOTS];
        int unsigned    held_count;
        bit             dropped;
        bit             ratio_mode = MODE_RATIO;
        ranked_beat_t   ranked_queue[$];
        int unsigned    mismatches;

        function bit ranks_below(rks_pkg::item_t a, rks_pkg::item_t b);
            logic [15:0] pa;
            logic [15:0] pb;
            logic [31:0] lhs;
            logic [31:0] rhs;
            pa = (a.power == 16'h0) ? 16'h1 : a.power;
            pb = (b.power == 16'h0) ? 16'h1 : b.power;
            lhs = 32'(a.capacity) * 32'(pb);
            rhs = 32'(b.capacity) * 32'(pa);
            if (ratio_mode && lhs != rhs) begin
                return lhs < rhs;
            end
            return pa < pb;
        endfunction

        function void load_item(rks_pkg::item_t it, bit last);
            int unsigned  order[SLOTS];
            int unsigned  i;
            int unsigned  j;
            int unsigned  pick;
            ranked_beat_t beat;
            if (held_count < SLOTS) begin
                held[held_count] = it;
                held_count++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) begin
                return;
            end
            // Stable ascending insertion; ratio mode reads the order backwards.
            for (i = 0; i < held_count; i++) begin
                j = i;
                while (j > 0 && ranks_below(held[i], held[order[j-1]])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (i = 0; i < held_count; i++) begin
                pick = ratio_mode ? order[held_count-1-i] : order[i];
                beat.tag = held[pick].tag;
                beat.capacity = held[pick].capacity;
                beat.power = held[pick].power;
                beat.overflow = dropped;
                beat.last = (i + 1 == held_count);
                ranked_queue.push_back(beat);
            end
            held_count = 0;
            dropped = 1'b0;
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_ranked_beat(ranked_beat_t seen);
            ranked_beat_t want;
            if (ranked_queue.size() == 0) begin
                report($sformatf("unexpected beat tag %0h", seen.tag));
                return;
            end
            want = ranked_queue.pop_front();
            if (seen.tag !== want.tag) begin
                report($sformatf("tag %0h, expected %0h", seen.tag, want.tag));
            end
            if (seen.capacity !== want.capacity) begin
                report($sformatf("capacity %0h, expected %0h", seen.capacity, want.capacity));
            end
            if (seen.power !== want.power) begin
                report($sformatf("power %0h, expected %0h", seen.power, want.power));
            end
            if (seen.overflow !== want.overflow) begin
                report($sformatf("overflow %0b, expected %0b", seen.overflow, want.overflow));
            end
            if (seen.last !== want.last) begin
                report($sformatf("last %0b, expected %0b", seen.last, want.last));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_wdata;

    sorted_set_predictor predictor = new;
    bit          hold_request;
    int unsigned cycle_count;

    ratio_key_stable_sorter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("ratio_key_stable_sorter regression: fail");
                $finish;
            end
        end
    end

    // Draws a random gap before each beat, with occasional stretches of back-to-back beats.
    function automatic int unsigned draw_gap(ref int unsigned calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic rks_pkg::item_t make_item(logic [15:0] cap, logic [15:0] pwr,
                                                 logic [7:0] tag);
        rks_pkg::item_t it;
        it.capacity = cap;
        it.power = pwr;
        it.tag = tag;
        return it;
    endfunction

    // Mixes fully random items with small, proportional and extreme values so that ties are common.
    function automatic rks_pkg::item_t draw_item();
        rks_pkg::item_t it;
        int unsigned    m;
        m = $urandom_range(1, 7);
        case ($urandom_range(0, 3))
            0: begin
                it.capacity = 16'($urandom_range(0, 65535));
                it.power = 16'($urandom_range(0, 65535));
            end
            1: begin
                it.capacity = 16'($urandom_range(0, 8));
                it.power = 16'($urandom_range(0, 4));
            end
            2: begin
                it.capacity = 16'($urandom_range(1, 9) * m);
                it.power = 16'($urandom_range(1, 9) * m);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: it.capacity = 16'h0000;
                    1: it.capacity = 16'hFFFF;
                    default: it.capacity = 16'($urandom_range(0, 65535));
                endcase
                case ($urandom_range(0, 2))
                    0: it.power = 16'h0000;
                    1: it.power = 16'h0001;
                    default: it.power = 16'hFFFF;
                endcase
            end
        endcase
        it.tag = 8'($urandom_range(0, 255));
        return it;
    endfunction

    int unsigned send_calm;

    task send_item(rks_pkg::item_t it, bit last);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= it;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predictor.load_item(it, last);
        @(negedge aclk);
    endtask

    task send_random_set(int unsigned size);
        int unsigned i;
        for (i = 0; i < size; i++) begin
            send_item(draw_item(), i + 1 == size);
        end
    endtask

    task set_mode(bit mode);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we <= 1'b0;
        predictor.ratio_mode = mode;
    endtask

    task wait_drained(int unsigned settle);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        while (predictor.ranked_queue.size() != 0) @(posedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    initial begin : result_side
        int unsigned  gap;
        int unsigned  calm;
        int unsigned  held_off;
        ranked_beat_t seen;
        m_tready = 1'b0;
        calm = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                for (held_off = 0; held_off < HOLD_CYCLES; held_off++) begin
                    @(negedge aclk);
                end
                hold_request = 1'b0;
            end else begin
                gap = draw_gap(calm);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            seen.tag = m_tdata[7:0];
            seen.capacity = m_tdata[23:8];
            seen.power = m_tdata[39:24];
            seen.overflow = m_tuser;
            seen.last = m_tlast;
            predictor.check_ranked_beat(seen);
            @(negedge aclk);
        end
    end

    initial begin : load_side
        int unsigned loaded;
        int unsigned phase;
        int unsigned size;
        int unsigned sets;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        hold_request = 1'b0;
        send_calm = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_mode(MODE_RATIO);
        send_item(make_item(16'hFFFF, 16'hFFFF, 8'hFF), 1'b0);
        send_item(make_item(16'h0000, 16'h0001, 8'h00), 1'b0);
        send_item(make_item(16'hFFFF, 16'h0001, 8'h01), 1'b0);
        send_item(make_item(16'h0001, 16'hFFFF, 8'h02), 1'b0);
        send_item(make_item(16'd100, 16'h0000, 8'h03), 1'b0);
        send_item(make_item(16'd100, 16'h0001, 8'h04), 1'b0);
        send_item(make_item(16'd200, 16'h0002, 8'h05), 1'b0);
        send_item(make_item(16'hAAAA, 16'h5555, 8'hAA), 1'b0);
        send_item(make_item(16'h5555, 16'hAAAA, 8'h55), 1'b1);
        send_item(make_item(16'd7, 16'd3, 8'h09), 1'b1);
        wait_drained(40);

        set_mode(MODE_POWER);
        send_item(make_item(16'd10, 16'd5, 8'h10), 1'b0);
        send_item(make_item(16'd20, 16'd5, 8'h11), 1'b0);
        send_item(make_item(16'hFFFF, 16'h0000, 8'h12), 1'b0);
        send_item(make_item(16'h0000, 16'h0001, 8'h13), 1'b0);
        send_item(make_item(16'h1234, 16'hFFFF, 8'h14), 1'b0);
        send_item(make_item(16'd30, 16'd5, 8'h15), 1'b1);
        wait_drained(40);

        loaded = 0;
        phase = 0;
        while (loaded < 150) begin
            if (phase < 2) begin
                set_mode(phase == 0 ? MODE_RATIO : MODE_POWER);
            end else begin
                set_mode($urandom_range(0, 1) ? MODE_RATIO : MODE_POWER);
            end
            if (phase == 1) begin
                // Fill the store and keep loading, so the closing beat itself is dropped.
                size = SLOTS + $urandom_range(1, 3);
                send_random_set(size);
                loaded += size;
            end
            if (phase == 2) begin
                hold_request = 1'b1;
            end
            sets = $urandom_range(2, 5);
            repeat (sets) begin
                size = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                send_random_set(size);
                loaded += size;
            end
            wait_drained(40);
            phase++;
        end

        wait_drained(100);
        if (predictor.mismatches == 0) begin
            $display("ratio_key_stable_sorter regression: pass");
        end else begin
            $display("ratio_key_stable_sorter regression: fail");
        end
        $finish;
    end

endmodule
